// ===== src/button_debounce_click_long_press_unit_assert.svh =====
// assertion macros for the button debounce unit
`ifndef BUTTON_DEBOUNCE_CLICK_LONG_PRESS_UNIT_ASSERT_SVH
`define BUTTON_DEBOUNCE_CLICK_LONG_PRESS_UNIT_ASSERT_SVH

// property checked on every clock edge outside reset
`define BDCLP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen on a valid result word
`define BDCLP_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/bdclp_pkg.sv =====
// shared types and constants for the button debounce unit
package bdclp_pkg;

    localparam int unsigned US_PER_MS     = 1000;
    localparam int unsigned DEB_MS_W      = 10;
    localparam int unsigned LONG_MS_W     = 16;
    localparam int unsigned CFG_DATA_W    = 16;
    localparam int unsigned TIME_W        = 32;
    localparam int unsigned DEB_US_W      = 20;
    localparam int unsigned LONG_US_W     = 26;

    localparam logic [DEB_MS_W-1:0]  DEB_MS_RST   = DEB_MS_W'(50);
    localparam logic [LONG_MS_W-1:0] LONG_MS_RST  = LONG_MS_W'(1000);
    localparam logic [DEB_US_W-1:0]  DEB_US_RST   = DEB_US_W'(50 * US_PER_MS);
    localparam logic [LONG_US_W-1:0] LONG_US_RST  = LONG_US_W'(1000 * US_PER_MS);

    typedef enum logic [0:0] {
        REG_DEBOUNCE_MS   = 1'b0,
        REG_LONG_PRESS_MS = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic              pin_level;
        logic [TIME_W-1:0] time_us;
    } sample_word_t;

    typedef struct packed {
        logic down_event;
        logic up_event;
        logic click_event;
        logic long_press_event;
        logic debounced_level;
    } result_word_t;

    // timing values in microseconds, handed from the register block to the core
    typedef struct packed {
        logic [DEB_US_W-1:0]  deb_us;
        logic [LONG_US_W-1:0] long_us;
    } timing_t;

endpackage

// ===== src/bdclp_stream_if.sv =====
// valid/ready channel carrying one word of a given type
interface bdclp_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/bdclp_cfg.sv =====
// configuration registers and their microsecond values
module bdclp_cfg
    import bdclp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output timing_t               timing
);

    logic [DEB_MS_W-1:0]  deb_ms_reg;
    logic [LONG_MS_W-1:0] long_ms_reg;
    logic [DEB_US_W-1:0]  deb_us_reg;
    logic [LONG_US_W-1:0] long_us_reg;
    logic [DEB_US_W-1:0]  deb_us_next;
    logic [LONG_US_W-1:0] long_us_next;

    // constant multiply, registered before use in the core
    assign deb_us_next  = DEB_US_W'(deb_ms_reg * DEB_US_W'(US_PER_MS));
    assign long_us_next = LONG_US_W'(long_ms_reg * LONG_US_W'(US_PER_MS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_ms_reg  <= DEB_MS_RST;
            long_ms_reg <= LONG_MS_RST;
            deb_us_reg  <= DEB_US_RST;
            long_us_reg <= LONG_US_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DEBOUNCE_MS:   deb_ms_reg  <= cfg_data[DEB_MS_W-1:0];
                    REG_LONG_PRESS_MS: long_ms_reg <= cfg_data[LONG_MS_W-1:0];
                    default:           ;
                endcase
            end
            deb_us_reg  <= deb_us_next;
            long_us_reg <= long_us_next;
        end
    end

    assign timing.deb_us  = deb_us_reg;
    assign timing.long_us = long_us_reg;

endmodule

// ===== src/bdclp_core.sv =====
// debounce state and event decisions for one sample
module bdclp_core
    import bdclp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  sample_word_t sample,
    input  timing_t      timing,
    output result_word_t result
);

    logic              prev_level_reg, prev_level_next;
    logic [TIME_W-1:0] fall_time_reg, fall_time_next;
    logic [TIME_W-1:0] rise_time_reg, rise_time_next;
    logic [TIME_W-1:0] press_time_reg, press_time_next;
    logic              down_rep_reg, down_rep_next;
    logic              up_rep_reg, up_rep_next;
    logic              long_rep_reg, long_rep_next;
    logic              stable_reg, stable_next;

    logic [TIME_W-1:0]    deb_w;
    logic [TIME_W-1:0]    long_w;
    logic [LONG_US_W-1:0] long_thr;
    logic [TIME_W-1:0]    since_fall;
    logic [TIME_W-1:0]    since_rise;
    logic [TIME_W-1:0]    since_press;
    logic                 down_ok;
    logic                 up_ok;
    logic                 long_ok;

    assign deb_w  = TIME_W'(timing.deb_us);
    assign long_w = TIME_W'(timing.long_us);

    // threshold counted from the down report, saturating at zero
    assign long_thr = (timing.long_us > LONG_US_W'(timing.deb_us))
                    ? timing.long_us - LONG_US_W'(timing.deb_us)
                    : '0;

    assign since_fall  = sample.time_us - fall_time_reg;
    assign since_rise  = sample.time_us - rise_time_reg;
    assign since_press = sample.time_us - press_time_reg;

    assign down_ok = (since_fall >= deb_w) && !down_rep_reg;
    assign up_ok   = (since_rise >= deb_w) && !up_rep_reg;
    // a fresh down report leaves zero time since press
    assign long_ok = !long_rep_reg && (down_ok
                   ? (long_thr == '0)
                   : (down_rep_reg && (since_press >= TIME_W'(long_thr))));

    always_comb
    begin
        prev_level_next = sample.pin_level;
        fall_time_next  = fall_time_reg;
        rise_time_next  = rise_time_reg;
        press_time_next = press_time_reg;
        down_rep_next   = down_rep_reg;
        up_rep_next     = up_rep_reg;
        long_rep_next   = long_rep_reg;
        stable_next     = stable_reg;
        result          = '0;

        if (sample.pin_level != prev_level_reg)
        begin
            if (!sample.pin_level)
            begin
                fall_time_next = sample.time_us;
            end
            else
            begin
                rise_time_next = sample.time_us;
            end
        end
        else if (!sample.pin_level)
        begin
            if (down_ok)
            begin
                stable_next       = 1'b0;
                result.down_event = 1'b1;
                press_time_next   = sample.time_us;
                down_rep_next     = 1'b1;
                up_rep_next       = 1'b0;
            end
            if (long_ok)
            begin
                result.long_press_event = 1'b1;
                long_rep_next           = 1'b1;
            end
        end
        else
        begin
            if (up_ok)
            begin
                stable_next        = 1'b1;
                result.up_event    = 1'b1;
                up_rep_next        = 1'b1;
                down_rep_next      = 1'b0;
                long_rep_next      = 1'b0;
                result.click_event = since_press < long_w;
            end
        end

        result.debounced_level = stable_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b1;
            fall_time_reg  <= '0;
            rise_time_reg  <= '0;
            press_time_reg <= '0;
            down_rep_reg   <= 1'b0;
            up_rep_reg     <= 1'b0;
            long_rep_reg   <= 1'b0;
            stable_reg     <= 1'b1;
        end
        else if (advance)
        begin
            prev_level_reg <= prev_level_next;
            fall_time_reg  <= fall_time_next;
            rise_time_reg  <= rise_time_next;
            press_time_reg <= press_time_next;
            down_rep_reg   <= down_rep_next;
            up_rep_reg     <= up_rep_next;
            long_rep_reg   <= long_rep_next;
            stable_reg     <= stable_next;
        end
    end

endmodule

// ===== src/button_debounce_click_long_press_unit.sv =====
// Button debouncer for an active-low pin with click and long-press events. One word,
// a pin sample with its microsecond timestamp, is taken per clock and gives one result
// word: the sample is held in an input register, the core updates its state and decides
// the events, and the result waits in an output register. The throughput of one word per
// clock, when the result is not stalled, is set by the state update in the core; a
// stalled result holds the input register and then the sample channel. A register write
// takes effect for words taken at the clock edge after the write and later, as the
// millisecond values are scaled to microseconds in a register stage.
module button_debounce_click_long_press_unit
    import bdclp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    bdclp_stream_if.sink          sample,
    bdclp_stream_if.source        result
);

    timing_t      timing;
    sample_word_t in_word_reg;
    logic         in_vld_reg;
    result_word_t core_word;
    result_word_t out_word_reg;
    logic         out_vld_reg;
    logic         advance;

    // the core moves a word whenever the output register is free or emptying
    assign advance      = in_vld_reg && (!out_vld_reg || result.ready);
    assign sample.ready = !in_vld_reg || advance;

    bdclp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .timing    (timing)
    );

    bdclp_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .sample  (in_word_reg),
        .timing  (timing),
        .result  (core_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (sample.ready)
            begin
                in_vld_reg <= sample.valid;
            end
            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            in_word_reg <= sample.data;
        end
        if (advance)
        begin
            out_word_reg <= core_word;
        end
    end

    assign result.valid = out_vld_reg;
    assign result.data  = out_word_reg;

endmodule

// ===== src/bdclp_checker.sv =====
// port-level checks for the button debounce unit, bound to the top level
`include "button_debounce_click_long_press_unit_assert.svh"

module bdclp_checker
    import bdclp_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         out_valid,
    input logic         out_ready,
    input result_word_t out_data
);

    `BDCLP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result word changed while stalled")
    `BDCLP_NEVER(a_down_up, out_valid && out_data.down_event && out_data.up_event, "down and up in one word")
    `BDCLP_NEVER(a_click_alone, out_valid && out_data.click_event && !out_data.up_event, "click without up")
    `BDCLP_NEVER(a_level_down, out_valid && (out_data.down_event || out_data.long_press_event) && out_data.debounced_level, "press event with high level")

endmodule

bind button_debounce_click_long_press_unit bdclp_checker u_bdclp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);
